// File: hdl/tked_pkg.sv
// Package for the touch key event detector: shared types and constants.
// No dependencies; every other file of the block but tked_fifo imports it.
`timescale 1ns / 1ps

package tked_pkg;

  localparam int OUT_KEYS  = 12;
  localparam int MAP_KEYS  = 12;
  localparam int PADS      = 16;
  localparam int PAD_IDX_W = 4;
  localparam int STAMP_W   = 32;
  localparam int HOLD_W    = 16;
  localparam int MAP_W     = MAP_KEYS * PAD_IDX_W;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MAP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT = 2'd2;

  localparam logic [MAP_W-1:0]   PAD_MAP_RST       = 48'hBA98_7654_3210;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_RST     = 16'd1000;
  localparam logic [STAMP_W-1:0] SLEEP_TIMEOUT_RST = 32'd30000;

  typedef struct packed {
    logic [OUT_KEYS-1:0] held_keys;
    logic [OUT_KEYS-1:0] pressed_keys;
    logic [OUT_KEYS-1:0] released_keys;
    logic [OUT_KEYS-1:0] hold_edge_keys;
    logic                state_changed;
    logic                asleep;
    logic                woke;
  } out_item_t;

  localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

// File: hdl/touch_key_event_detector.sv
// An accepted transfer is written into the middle queue, moves through the back part into the
// output queue and then clears empty. Throughput: one item per cycle while neither queue is full;
// the front and back parts are joined by a two-entry queue, with a two-entry queue at the output.
// Reset (rst_n low, synchronous) empties both queues, clears key, hold and idle state,
// wakes the block and restores the configuration registers to their defaults.
// Top level; depends on tked_pkg, tked_fifo, tked_front and tked_back.
`timescale 1ns / 1ps

module touch_key_event_detector
  import tked_pkg::*;
#(
  parameter int KEYS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_sample_valid,
  input  logic [PADS-1:0]      in_raw_pads,
  input  logic [STAMP_W-1:0]   in_now_ms,
  output logic                 empty,
  input  logic                 pop,
  output logic [OUT_KEYS-1:0]  out_held_keys,
  output logic [OUT_KEYS-1:0]  out_pressed_keys,
  output logic [OUT_KEYS-1:0]  out_released_keys,
  output logic [OUT_KEYS-1:0]  out_hold_edge_keys,
  output logic                 out_state_changed,
  output logic                 out_asleep,
  output logic                 out_woke,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int MID_W = 3 * KEYS + STAMP_W + 1;

  logic [MAP_W-1:0]   pad_map_r;
  logic [HOLD_W-1:0]  hold_time_r;
  logic [STAMP_W-1:0] sleep_timeout_r;

  logic               accept;
  logic [MID_W-1:0]   front_item, mid_item;
  logic               mid_empty, out_full, go;
  out_item_t          back_result, out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_map_r       <= PAD_MAP_RST;
      hold_time_r     <= HOLD_TIME_RST;
      sleep_timeout_r <= SLEEP_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PAD_MAP:       pad_map_r       <= cfg_wdata[MAP_W-1:0];
        CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata[HOLD_W-1:0];
        CFG_SLEEP_TIMEOUT: sleep_timeout_r <= cfg_wdata[STAMP_W-1:0];
        default:           ;
      endcase
    end
  end

  assign accept = push && !full;
  assign go     = !mid_empty && !out_full;

  tked_front #(.KEYS(KEYS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sample_valid (in_sample_valid),
    .raw_pads     (in_raw_pads),
    .now_ms       (in_now_ms),
    .pad_map      (pad_map_r),
    .item         (front_item)
  );

  tked_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (go),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  tked_back #(.KEYS(KEYS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go),
    .item             (mid_item),
    .hold_time_ms     (hold_time_r),
    .sleep_timeout_ms (sleep_timeout_r),
    .result           (back_result)
  );

  tked_fifo #(.WIDTH(OUT_ITEM_W), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (go),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

  assign out_held_keys      = out_item.held_keys;
  assign out_pressed_keys   = out_item.pressed_keys;
  assign out_released_keys  = out_item.released_keys;
  assign out_hold_edge_keys = out_item.hold_edge_keys;
  assign out_state_changed  = out_item.state_changed;
  assign out_asleep         = out_item.asleep;
  assign out_woke           = out_item.woke;

endmodule

// File: hdl/tked_fifo.sv
// Small first-in first-out queue used between the front and back parts and at the output.
// Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps

module tked_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/tked_front.sv
// Front part: remaps the raw pads into the key mask and finds press and release edges.
// Depends on tked_pkg; feeds a classified item into the middle queue.
`timescale 1ns / 1ps

module tked_front
  import tked_pkg::*;
#(
  parameter int KEYS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      sample_valid,
  input  logic [PADS-1:0]           raw_pads,
  input  logic [STAMP_W-1:0]        now_ms,
  input  logic [MAP_W-1:0]          pad_map,
  output logic [3*KEYS+STAMP_W:0]   item
);

  logic [KEYS-1:0] key_mask_r, key_mask_nxt;
  logic [KEYS-1:0] remap;
  logic [KEYS-1:0] pressed, released;
  logic            changed;

  for (genvar i = 0; i < KEYS; i++) begin : g_remap
    if (i < MAP_KEYS) begin : g_map
      assign remap[i] = raw_pads[pad_map[PAD_IDX_W*i +: PAD_IDX_W]];
    end else begin : g_pad0
      assign remap[i] = raw_pads[0];
    end
  end

  always_comb begin
    key_mask_nxt = key_mask_r;
    pressed      = '0;
    released     = '0;
    changed      = 1'b0;
    if (sample_valid) begin
      key_mask_nxt = remap;
      pressed      = ~key_mask_r & remap;
      released     = key_mask_r & ~remap;
      changed      = (remap != key_mask_r);
    end
  end

  assign item = {changed, key_mask_nxt, pressed, released, now_ms};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r <= '0;
    end else if (accept) begin
      key_mask_r <= key_mask_nxt;
    end
  end

endmodule

// File: hdl/tked_back.sv
// Back part: per-key hold timing, idle timer and sleep/wake, building the result item.
// Depends on tked_pkg; takes classified items from the middle queue.
`timescale 1ns / 1ps

module tked_back
  import tked_pkg::*;
#(
  parameter int KEYS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [3*KEYS+STAMP_W:0] item,
  input  logic [HOLD_W-1:0]       hold_time_ms,
  input  logic [STAMP_W-1:0]      sleep_timeout_ms,
  output out_item_t               result
);

  localparam int MID_W = 3 * KEYS + STAMP_W + 1;

  logic [STAMP_W-1:0] press_stamp_r [KEYS];
  logic [KEYS-1:0]    hold_fired_r, hold_fired_nxt;
  logic [STAMP_W-1:0] last_activity_r, last_activity_nxt;
  logic               sleep_mode_r, sleep_mode_nxt;

  logic [STAMP_W-1:0] now;
  logic [KEYS-1:0]    released, pressed, mask, hold_edge;
  logic               changed, any_press, woke, awake_mid;

  assign now      = item[STAMP_W-1:0];
  assign released = item[STAMP_W +: KEYS];
  assign pressed  = item[STAMP_W+KEYS +: KEYS];
  assign mask     = item[STAMP_W+2*KEYS +: KEYS];
  assign changed  = item[MID_W-1];

  assign any_press = (pressed != '0);

  for (genvar k = 0; k < KEYS; k++) begin : g_hold
    logic [STAMP_W-1:0] since;
    assign since = now - press_stamp_r[k];
    assign hold_edge[k] = mask[k] && !pressed[k] && !released[k] && !hold_fired_r[k] &&
                          (since >= STAMP_W'(hold_time_ms));
  end

  always_comb begin
    woke              = sleep_mode_r && any_press;
    awake_mid         = !sleep_mode_r || any_press;
    last_activity_nxt = any_press ? now : last_activity_r;
    hold_fired_nxt    = (hold_fired_r & ~pressed) | hold_edge;
    sleep_mode_nxt    = !awake_mid || ((now - last_activity_nxt) >= sleep_timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_fired_r    <= '0;
      last_activity_r <= '0;
      sleep_mode_r    <= 1'b0;
    end else if (go) begin
      hold_fired_r    <= hold_fired_nxt;
      last_activity_r <= last_activity_nxt;
      sleep_mode_r    <= sleep_mode_nxt;
    end
  end

  for (genvar k = 0; k < KEYS; k++) begin : g_stamp
    always_ff @(posedge clk) begin
      if (go && pressed[k]) begin
        press_stamp_r[k] <= now;
      end
    end
  end

  for (genvar i = 0; i < OUT_KEYS; i++) begin : g_out
    if (i < KEYS) begin : g_key
      assign result.held_keys[i]      = mask[i];
      assign result.pressed_keys[i]   = pressed[i];
      assign result.released_keys[i]  = released[i];
      assign result.hold_edge_keys[i] = hold_edge[i];
    end else begin : g_none
      assign result.held_keys[i]      = 1'b0;
      assign result.pressed_keys[i]   = 1'b0;
      assign result.released_keys[i]  = 1'b0;
      assign result.hold_edge_keys[i] = 1'b0;
    end
  end

  assign result.state_changed = changed;
  assign result.asleep        = sleep_mode_nxt;
  assign result.woke          = woke;

endmodule

// File: hdl/tked_checker.sv
// Port-level checker for the touch key event detector, bound to the top level.
// Depends on tked_pkg; observes the top level's ports only.
`timescale 1ns / 1ps

module tked_checker
  import tked_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic [OUT_KEYS-1:0]  out_held_keys,
  input logic [OUT_KEYS-1:0]  out_pressed_keys,
  input logic [OUT_KEYS-1:0]  out_released_keys,
  input logic [OUT_KEYS-1:0]  out_hold_edge_keys,
  input logic                 out_state_changed,
  input logic                 out_woke
);

  // Reset drains every queued result.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A key cannot both go down and come up in one transfer, and a press leaves it down.
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_pressed_keys & out_released_keys) == '0) &&
               ((out_pressed_keys & ~out_held_keys) == '0))
    else $error("inconsistent press or release edges");

  // A hold edge fires only on a key that is down and had no edge in this transfer.
  a_hold_edge: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_hold_edge_keys & ~out_held_keys) == '0) &&
               ((out_hold_edge_keys & (out_pressed_keys | out_released_keys)) == '0))
    else $error("hold edge on a key that is up or has an edge");

  // Any edge means the sample differed from the previous key mask.
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && ((out_pressed_keys | out_released_keys) != '0) |-> out_state_changed)
    else $error("edge reported without a state change");

  // Only a press can wake the block.
  a_woke: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_woke |-> (out_pressed_keys != '0))
    else $error("wake reported without a press");

endmodule

bind touch_key_event_detector tked_checker u_tked_checker (.*);

// File: tb/sv/tked_event_checker.sv
// Event checker for touch_key_event_detector: predicts one event record per accepted tick.
// It watches the tick, event and register ports and compares every popped record.
// Depends on tked_pkg.
`timescale 1ns / 1ps

module tked_event_checker
  import tked_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic                 in_sample_valid,
  input  logic [PADS-1:0]      in_raw_pads,
  input  logic [STAMP_W-1:0]   in_now_ms,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [OUT_KEYS-1:0]  out_held_keys,
  input  logic [OUT_KEYS-1:0]  out_pressed_keys,
  input  logic [OUT_KEYS-1:0]  out_released_keys,
  input  logic [OUT_KEYS-1:0]  out_hold_edge_keys,
  input  logic                 out_state_changed,
  input  logic                 out_asleep,
  input  logic                 out_woke,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);

  logic [MAP_W-1:0]    pad_map_q;
  logic [HOLD_W-1:0]   hold_time_q;
  logic [STAMP_W-1:0]  sleep_timeout_q;

  logic [OUT_KEYS-1:0] key_mask_q;
  logic [STAMP_W-1:0]  press_stamp_q [OUT_KEYS];
  logic [OUT_KEYS-1:0] hold_fired_q;
  logic [STAMP_W-1:0]  last_activity_q;
  logic                asleep_q;

  out_item_t expected_events[$];
  int        mismatches = 0;
  int        events_due = 0;

  assign errors  = mismatches;
  assign pending = events_due;

  function automatic out_item_t advance_keypad(input logic fresh,
                                               input logic [PADS-1:0] raw,
                                               input logic [STAMP_W-1:0] now);
    out_item_t           ev;
    logic [OUT_KEYS-1:0] next_mask;
    logic [STAMP_W-1:0]  age;
    ev = '0;
    if (fresh) begin
      for (int k = 0; k < OUT_KEYS; k++) begin
        next_mask[k] = raw[pad_map_q[k*PAD_IDX_W +: PAD_IDX_W]];
      end
      ev.pressed_keys  = ~key_mask_q & next_mask;
      ev.released_keys = key_mask_q & ~next_mask;
      ev.state_changed = (next_mask != key_mask_q);
      key_mask_q = next_mask;
      if (ev.pressed_keys != '0) begin
        last_activity_q = now;
      end
      for (int k = 0; k < OUT_KEYS; k++) begin
        if (ev.pressed_keys[k]) begin
          press_stamp_q[k] = now;
          hold_fired_q[k] = 1'b0;
          if (asleep_q) begin
            asleep_q = 1'b0;
            last_activity_q = now;
            ev.woke = 1'b1;
          end
        end
      end
    end
    for (int k = 0; k < OUT_KEYS; k++) begin
      age = now - press_stamp_q[k];
      if (key_mask_q[k] && !ev.pressed_keys[k] && !ev.released_keys[k] &&
          !hold_fired_q[k] && age >= STAMP_W'(hold_time_q)) begin
        hold_fired_q[k] = 1'b1;
        ev.hold_edge_keys[k] = 1'b1;
      end
    end
    age = now - last_activity_q;
    if (!asleep_q && age >= sleep_timeout_q) begin
      asleep_q = 1'b1;
    end
    ev.held_keys = key_mask_q;
    ev.asleep = asleep_q;
    return ev;
  endfunction

  task automatic check_field(input string field, input logic [OUT_KEYS-1:0] want,
                             input logic [OUT_KEYS-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pad_map_q = PAD_MAP_RST;
      hold_time_q = HOLD_TIME_RST;
      sleep_timeout_q = SLEEP_TIMEOUT_RST;
      key_mask_q = '0;
      hold_fired_q = '0;
      last_activity_q = '0;
      asleep_q = 1'b0;
      for (int k = 0; k < OUT_KEYS; k++) begin
        press_stamp_q[k] = '0;
      end
      expected_events.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PAD_MAP:       pad_map_q = cfg_wdata[MAP_W-1:0];
          CFG_HOLD_TIME:     hold_time_q = cfg_wdata[HOLD_W-1:0];
          CFG_SLEEP_TIMEOUT: sleep_timeout_q = cfg_wdata[STAMP_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: event record transfer with nothing expected, actual held %h",
                   $time, out_held_keys);
        end else begin
          want = expected_events.pop_front();
          check_field("held_keys", want.held_keys, out_held_keys);
          check_field("pressed_keys", want.pressed_keys, out_pressed_keys);
          check_field("released_keys", want.released_keys, out_released_keys);
          check_field("hold_edge_keys", want.hold_edge_keys, out_hold_edge_keys);
          check_field("state_changed", OUT_KEYS'(want.state_changed),
                      OUT_KEYS'(out_state_changed));
          check_field("asleep", OUT_KEYS'(want.asleep), OUT_KEYS'(out_asleep));
          check_field("woke", OUT_KEYS'(want.woke), OUT_KEYS'(out_woke));
        end
      end
      if (push && !full) begin
        expected_events.push_back(advance_keypad(in_sample_valid, in_raw_pads, in_now_ms));
      end
    end
    events_due <= expected_events.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for touch_key_event_detector: clock, reset, tick stimulus and verdict.
// Instantiates the block and tked_event_checker; depends on tked_pkg.
`timescale 1ns / 1ps

module tb;
  import tked_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic                 in_sample_valid;
  logic [PADS-1:0]      in_raw_pads;
  logic [STAMP_W-1:0]   in_now_ms;
  logic                 empty;
  logic                 pop;
  logic [OUT_KEYS-1:0]  out_held_keys;
  logic [OUT_KEYS-1:0]  out_pressed_keys;
  logic [OUT_KEYS-1:0]  out_released_keys;
  logic [OUT_KEYS-1:0]  out_hold_edge_keys;
  logic                 out_state_changed;
  logic                 out_asleep;
  logic                 out_woke;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   pending;

  int                   gap_pct;
  int                   stall_pct;
  bit                   calm;
  bit                   squeeze;
  int                   quiet_cycles;
  logic [STAMP_W-1:0]   clock_ms;
  logic [PADS-1:0]      pads_now;

  touch_key_event_detector dut (.*);

  tked_event_checker event_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic offer(input logic fresh, input logic [PADS-1:0] raw,
                       input logic [STAMP_W-1:0] now);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    push <= 1'b1;
    in_sample_valid <= fresh;
    in_raw_pads <= raw;
    in_now_ms <= now;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [MAP_W-1:0] map, input logic [HOLD_W-1:0] hold,
                              input logic [STAMP_W-1:0] timeout);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PAD_MAP;
    cfg_wdata <= CFG_W'(map);
    @(posedge clk);
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= CFG_W'(hold);
    @(posedge clk);
    cfg_index <= CFG_SLEEP_TIMEOUT;
    cfg_wdata <= CFG_W'(timeout);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly short steps so keys stay down across several samples, with rare long
  // or arbitrary jumps that reach the sleep timeout and the wrap of the time stamp.
  task automatic random_tick();
    logic fresh;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) clock_ms = clock_ms + $urandom_range(0, 120);
    else if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 3000);
    else if (pick < 97) clock_ms = clock_ms + $urandom_range(0, 40000);
    else clock_ms = $urandom();
    fresh = ($urandom_range(0, 3) != 0);
    if (fresh) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) pads_now = PADS'($urandom());
      else if (pick < 18) pads_now = '0;
      else if (pick < 23) pads_now = '1;
      else if (pick < 70) pads_now = pads_now ^ (PADS'(1) << $urandom_range(0, PADS - 1));
    end
    offer(fresh, fresh ? pads_now : PADS'($urandom()), clock_ms);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("touch_key_event_detector regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (squeeze) begin
        pop <= 1'b0;
        repeat (150) @(posedge clk);
        squeeze = 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_sample_valid = 1'b0;
    in_raw_pads = '0;
    in_now_ms = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_PAD_MAP;
    cfg_wdata = '0;
    quiet_cycles = 0;
    gap_pct = 20;
    stall_pct = 20;
    calm = 1'b0;
    squeeze = 1'b0;
    clock_ms = '0;
    pads_now = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: ticks without a sample, hold edges, sleep, wake, time wrap.
    offer(1'b0, 16'hFFFF, 32'd0);
    offer(1'b1, 16'h0001, 32'd10);
    offer(1'b0, 16'h0000, 32'd500);
    offer(1'b0, 16'hFFFF, 32'd1010);
    offer(1'b1, 16'hFFFF, 32'd1020);
    offer(1'b1, 16'hFFFF, 32'd1020);
    offer(1'b1, 16'h0FFE, 32'd2019);
    offer(1'b1, 16'h0FFE, 32'd2020);
    offer(1'b1, 16'hF000, 32'd2100);
    offer(1'b0, 16'h0000, 32'd31020);
    offer(1'b1, 16'h0006, 32'd31100);
    offer(1'b1, 16'h0000, 32'd31200);
    offer(1'b1, 16'h0001, 32'hFFFF_FF00);
    offer(1'b0, 16'h0000, 32'h0000_02E8);
    offer(1'b1, 16'h8001, 32'hFFFF_FFFF);
    drain();
    // Zero hold time and zero sleep timeout.
    program_regs(PAD_MAP_RST, 16'd0, 32'd0);
    offer(1'b1, 16'h0003, 32'd100);
    offer(1'b0, 16'h0000, 32'd100);
    offer(1'b1, 16'h0000, 32'd101);
    drain();
    // Every key on pad 0, longest hold time and timeout.
    program_regs('0, 16'hFFFF, 32'hFFFF_FFFF);
    offer(1'b1, 16'h0001, 32'd5);
    offer(1'b0, 16'h0000, 32'd65540);
    offer(1'b1, 16'hFFFE, 32'd70000);
    drain();
    // Every key on pad 15.
    program_regs('1, 16'd5, 32'd0);
    offer(1'b1, 16'h8000, 32'd1);
    offer(1'b1, 16'h7FFF, 32'd2);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: program_regs(PAD_MAP_RST, HOLD_TIME_RST, SLEEP_TIMEOUT_RST);
        1: program_regs(MAP_W'({$urandom(), $urandom()}), 16'd0, 32'd0);
        2: program_regs(MAP_W'({$urandom(), $urandom()}), 16'hFFFF, 32'hFFFF_FFFF);
        3: program_regs('0, HOLD_W'($urandom_range(0, 300)), $urandom_range(0, 5000));
        4: program_regs('1, 16'd200, 32'd1000);
        default: program_regs(MAP_W'({$urandom(), $urandom()}),
                              HOLD_W'($urandom_range(0, 65535)), $urandom());
      endcase
      case (phase)
        0: begin gap_pct = 15; stall_pct = 10; end
        1: begin gap_pct = 30; stall_pct = 5; end
        2: begin gap_pct = 0; stall_pct = 30; end
        3: begin gap_pct = 10; stall_pct = 0; end
        4: begin gap_pct = 25; stall_pct = 15; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      calm = (phase == 5);
      for (int n = 0; n < 250; n++) begin
        if (phase == 1 && n == 20) squeeze = 1'b1;
        random_tick();
      end
    end

    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("touch_key_event_detector regression: pass");
    end else begin
      $display("touch_key_event_detector regression: fail");
    end
    $finish;
  end

endmodule
